// ----- hw/rtl/qcet_pkg.sv -----
// Package with item types and constants of the quad corner extreme tracker.
`timescale 1ns / 1ps

package qcet_pkg;

	// Width of the coordinate fields on the item channels.
	localparam int unsigned OUT_COORD_W = 12;

	// Default internal coordinate width.
	localparam int unsigned COORD_BITS_DEFAULT = 12;

	typedef struct packed {
		logic [OUT_COORD_W-1:0] point_x;
		logic [OUT_COORD_W-1:0] point_y;
		logic                   last_point;
	} point_item_t;

	typedef struct packed {
		logic [OUT_COORD_W-1:0] top_left_x;
		logic [OUT_COORD_W-1:0] top_left_y;
		logic [OUT_COORD_W-1:0] bottom_left_x;
		logic [OUT_COORD_W-1:0] bottom_left_y;
		logic [OUT_COORD_W-1:0] bottom_right_x;
		logic [OUT_COORD_W-1:0] bottom_right_y;
		logic [OUT_COORD_W-1:0] top_right_x;
		logic [OUT_COORD_W-1:0] top_right_y;
		logic                   corners_distinct;
	} corner_item_t;

endpackage

// ----- hw/rtl/qcet_stream_if.sv -----
// Valid/ready item channel used on both sides of the corner tracker.
`timescale 1ns / 1ps

interface qcet_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/quad_corner_extreme_tracker_unit.sv -----
// Top level of the quad corner extreme tracker: tracks sum/difference extremes per contour.
//
//   channel   direction  payload        accepted when
//   points    sink       point_item_t   points.valid && points.ready
//   corners   source     corner_item_t  corners.valid && corners.ready
//
// One point is accepted in every cycle while the input register is not waiting.
// A point is registered at the input; the four compares and the corner update
// then work from that register, and the corners of a contour are written into
// the output register when its last point leaves the input register. The input
// register waits only when it holds a last point and the output register is still full.
// Reset clears the valid flags and makes the next point start a contour.
`timescale 1ns / 1ps

module quad_corner_extreme_tracker_unit #(
	parameter int unsigned COORD_BITS = qcet_pkg::COORD_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	qcet_stream_if.sink           points,
	qcet_stream_if.source         corners
);

	localparam int unsigned OW = qcet_pkg::OUT_COORD_W;

	typedef struct packed {
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] x;
	} pt_t;

	// Input stage
	logic valid_s1;
	pt_t  pt_s1;
	logic last_s1;

	// Corner state
	logic first_pending_q;
	pt_t  min_sum_q, max_sum_q, min_diff_q, max_diff_q;
	pt_t  min_sum_d, max_sum_d, min_diff_d, max_diff_d;

	// Output register
	logic                  out_valid_q;
	qcet_pkg::corner_item_t out_data_q;

	logic advance, emit, in_fire, distinct;
	logic [COORD_BITS:0] sum_p, sum_min, sum_max;
	logic [COORD_BITS:0] dif_p, dif_min, dif_max;

	// A last point needs room in the output register; other points always move on.
	assign advance = valid_s1 && (!last_s1 || !out_valid_q || corners.ready);
	assign emit    = advance && last_s1;
	assign points.ready = !valid_s1 || advance;
	assign in_fire = points.valid && points.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (points.ready) begin
			valid_s1 <= points.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pt_s1.x <= COORD_BITS'(points.data.point_x);
			pt_s1.y <= COORD_BITS'(points.data.point_y);
			last_s1 <= points.data.last_point;
		end
	end

	// The difference key is x - y biased by the coordinate maximum: x + ~y.
	assign sum_p   = {1'b0, pt_s1.x} + {1'b0, pt_s1.y};
	assign sum_min = {1'b0, min_sum_q.x} + {1'b0, min_sum_q.y};
	assign sum_max = {1'b0, max_sum_q.x} + {1'b0, max_sum_q.y};
	assign dif_p   = {1'b0, pt_s1.x} + {1'b0, ~pt_s1.y};
	assign dif_min = {1'b0, min_diff_q.x} + {1'b0, ~min_diff_q.y};
	assign dif_max = {1'b0, max_diff_q.x} + {1'b0, ~max_diff_q.y};

	// Minima keep the first point on a tie, maxima take the latest one.
	always_comb begin
		if (first_pending_q) begin
			min_sum_d  = pt_s1;
			max_sum_d  = pt_s1;
			min_diff_d = pt_s1;
			max_diff_d = pt_s1;
		end else begin
			min_sum_d  = (sum_p <  sum_min) ? pt_s1 : min_sum_q;
			max_sum_d  = (sum_p >= sum_max) ? pt_s1 : max_sum_q;
			min_diff_d = (dif_p <  dif_min) ? pt_s1 : min_diff_q;
			max_diff_d = (dif_p >= dif_max) ? pt_s1 : max_diff_q;
		end
	end

	assign distinct = (min_sum_d != min_diff_d) && (min_sum_d != max_sum_d) &&
		(min_sum_d != max_diff_d) && (min_diff_d != max_sum_d) &&
		(min_diff_d != max_diff_d) && (max_sum_d != max_diff_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pending_q <= 1'b1;
			min_sum_q       <= '0;
			max_sum_q       <= '0;
			min_diff_q      <= '0;
			max_diff_q      <= '0;
		end else if (advance) begin
			first_pending_q <= last_s1;
			min_sum_q       <= min_sum_d;
			max_sum_q       <= max_sum_d;
			min_diff_q      <= min_diff_d;
			max_diff_q      <= max_diff_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (corners.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q.top_left_x       <= OW'(min_sum_d.x);
			out_data_q.top_left_y       <= OW'(min_sum_d.y);
			out_data_q.bottom_left_x    <= OW'(min_diff_d.x);
			out_data_q.bottom_left_y    <= OW'(min_diff_d.y);
			out_data_q.bottom_right_x   <= OW'(max_sum_d.x);
			out_data_q.bottom_right_y   <= OW'(max_sum_d.y);
			out_data_q.top_right_x      <= OW'(max_diff_d.x);
			out_data_q.top_right_y      <= OW'(max_diff_d.y);
			out_data_q.corners_distinct <= distinct;
		end
	end

	assign corners.valid = out_valid_q;
	assign corners.data  = out_data_q;

	// A result appears only after a last point has left the input stage.
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result appeared without a last point");

	// After a contour is emitted, the next point starts a new contour.
	a_restart_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> first_pending_q)
		else $error("contour start not armed after emit");

	// A held input point keeps its value until it can move on.
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(pt_s1) && $stable(last_s1)))
		else $error("stalled input stage lost its point");

	// A single-point contour never reports distinct corners.
	a_single_point: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && first_pending_q) |=> !out_data_q.corners_distinct)
		else $error("single point contour reported distinct corners");

endmodule
